FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clk, idle while rst is high.
`define ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every rising edge of clk, reset cycles included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/ffef_pkg.sv
package ffef_pkg;

  localparam int MAX_EXTENTS_DEF = 16;
  localparam int ALIGN_SHIFT_DEF = 3;

  localparam int ADDR_W = 32;

  // command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // status codes
  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_FOUND   = 2'd1;
  localparam logic [1:0] STAT_NOSPACE = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_REGION_BASE   = 2'd0;
  localparam logic [1:0] REG_REGION_LENGTH = 2'd1;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] len;
  } extent_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] extent_start;
    logic [ADDR_W-1:0] extent_length;
    logic [ADDR_W-1:0] request_length;
  } request_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] found_address;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_CMP,
    ST_Q_RD,
    ST_Q_CMP,
    ST_Q_TAIL,
    ST_DONE
  } state_t;

endpackage

FILE: design/ffef_mem.sv
module ffef_mem #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output ffef_pkg::extent_t     rd_data,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_addr,
  input  ffef_pkg::extent_t     wr_data
);
  import ffef_pkg::*;

  extent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/ffef_engine.sv
`include "assert_macros.svh"

module ffef_engine #(
  parameter int MAX_EXTENTS = 16,
  parameter int ALIGN_SHIFT = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  ffef_pkg::request_t   req,
  input  logic [31:0]          region_base,
  input  logic [31:0]          region_length,
  output logic                 res_valid,
  input  logic                 res_ready,
  output ffef_pkg::result_t    res
);
  import ffef_pkg::*;

  localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_EXTENTS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [ADDR_W:0] ALIGN_MASK = (33'd1 << ALIGN_SHIFT) - 33'd1;

  state_t state, state_next;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  ptr;
  logic [ADDR_W:0]   cursor;
  logic [ADDR_W:0]   need;
  logic [ADDR_W:0]   tail_end;
  extent_t           new_ext;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  extent_t           rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  extent_t           wr_data;

  logic              accept;
  logic [CNT_W-1:0]  ptr_dec;
  logic              add_shift;
  logic [ADDR_W:0]   gap_top;
  logic signed [ADDR_W+1:0] gap;
  logic              fit;
  logic [ADDR_W:0]   need_in;

  assign accept    = req_valid && req_ready;
  assign ptr_dec   = ptr - CNT_ONE;
  assign add_shift = new_ext.base < rd_data.base;
  assign need_in   = ({1'b0, req.request_length} + ALIGN_MASK) & ~ALIGN_MASK;

  // one shared subtract and compare serves every gap, the tail gap included
  assign gap_top = (state == ST_Q_TAIL) ? tail_end : {1'b0, rd_data.base};
  assign gap     = $signed({1'b0, gap_top}) - $signed({1'b0, cursor});
  assign fit     = gap >= $signed({1'b0, need});

  ffef_mem #(
    .DEPTH (MAX_EXTENTS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.cmd)
            CMD_ADD:   state_next = (count == CNT_MAX) ? ST_DONE : ST_ADD_RD;
            CMD_QUERY: state_next = (req.request_length == '0) ? ST_DONE : ST_Q_RD;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_ADD_RD:  state_next = (ptr == '0) ? ST_DONE : ST_ADD_CMP;
      ST_ADD_CMP: state_next = add_shift ? ST_ADD_RD : ST_DONE;
      ST_Q_RD:    state_next = (ptr == count) ? ST_Q_TAIL : ST_Q_CMP;
      ST_Q_CMP:   state_next = fit ? ST_DONE : ST_Q_RD;
      ST_Q_TAIL:  state_next = ST_DONE;
      ST_DONE:    state_next = res_ready ? ST_IDLE : ST_DONE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    res_valid = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = ptr[IDX_W-1:0];
    wr_en     = 1'b0;
    wr_addr   = ptr[IDX_W-1:0];
    wr_data   = new_ext;
    case (state)
      ST_IDLE: req_ready = 1'b1;
      ST_ADD_RD: begin
        if (ptr == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_dec[IDX_W-1:0];
        end
      end
      ST_ADD_CMP: begin
        // move the larger entry up one slot, or drop the new one in here
        wr_en   = 1'b1;
        wr_data = add_shift ? rd_data : new_ext;
      end
      ST_Q_RD: rd_en = (ptr != count);
      ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept && req.cmd == CMD_CLEAR) begin
        count <= '0;
      end else if ((state == ST_ADD_RD && ptr == '0) ||
                   (state == ST_ADD_CMP && !add_shift)) begin
        count <= count + CNT_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          new_ext.base      <= req.extent_start;
          new_ext.len       <= req.extent_length;
          need              <= need_in;
          cursor            <= {1'b0, region_base};
          tail_end          <= {1'b0, region_base} + {1'b0, region_length};
          res.found_address <= '0;
          case (req.cmd)
            CMD_ADD: begin
              ptr        <= count;
              res.status <= (count == CNT_MAX) ? STAT_FULL : STAT_DONE;
            end
            CMD_QUERY: begin
              ptr        <= '0;
              res.status <= STAT_NOSPACE;
            end
            default: res.status <= STAT_DONE;
          endcase
        end
      end
      ST_ADD_CMP: begin
        if (add_shift) begin
          ptr <= ptr_dec;
        end
      end
      ST_Q_CMP: begin
        if (fit) begin
          res.status        <= STAT_FOUND;
          res.found_address <= cursor[ADDR_W-1:0];
        end else begin
          cursor <= {1'b0, rd_data.base} + {1'b0, rd_data.len};
          ptr    <= ptr + CNT_ONE;
        end
      end
      ST_Q_TAIL: begin
        if (fit) begin
          res.status        <= STAT_FOUND;
          res.found_address <= cursor[ADDR_W-1:0];
        end
      end
      default: ;
    endcase
  end

  `ASSERT_RUN(a_count_bound, count <= CNT_MAX, "extent count above table size")
  `ASSERT_RUN(a_q_ptr, (state == ST_Q_CMP) |-> (ptr < count), "query read past stored count")
  `ASSERT_RUN(a_add_ptr, (state == ST_ADD_CMP) |-> (ptr != '0 && ptr <= count),
              "insert pointer out of range")
  `ASSERT_RUN(a_clear, (accept && req.cmd == CMD_CLEAR) |=> (count == '0),
              "clear left entries behind")

endmodule

FILE: design/first_fit_extent_finder.sv
// First-fit free space finder over a sorted table of occupied extents.
//
// Input channel (in_valid/in_ready) transfers one command: clear the table,
// add an extent (extent_start, extent_length) or query a request_length.
// Output channel (out_valid/out_ready) transfers exactly one result per
// command: status and found_address.
// Configuration: pulse cfg_write with cfg_index 0 (region_base) or 1
// (region_length) and cfg_data; write only while no command is in flight.
//
// Commands run one at a time through a one-port-read, one-port-write extent
// memory with a registered read. Clear, an unused code, an add to a full
// table and a zero-length query go straight to the result. An add walks
// down from the end of the table, reading each entry and moving it up one
// slot while its base is above the new base, then writes the new extent.
// A query walks up from the first entry, reading each and testing the gap
// before it; it stops at the first gap that fits, else tests the tail gap.
// A new command is taken while the previous result still waits in the
// output register; when the receiver stalls with both full, in_ready drops.
// Reset empties the table and the output register and zeroes both region
// registers; no clearing pass runs over the memory.
`include "assert_macros.svh"

module first_fit_extent_finder #(
  parameter int MAX_EXTENTS = ffef_pkg::MAX_EXTENTS_DEF,
  parameter int ALIGN_SHIFT = ffef_pkg::ALIGN_SHIFT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [31:0] extent_start,
  input  logic [31:0] extent_length,
  input  logic [31:0] request_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] found_address
);
  import ffef_pkg::*;

  logic [31:0] region_base;
  logic [31:0] region_length;
  request_t    req;
  result_t     res;
  logic        res_valid;
  logic        res_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base   <= '0;
      region_length <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_REGION_BASE:   region_base   <= cfg_data;
        REG_REGION_LENGTH: region_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign req.cmd            = cmd;
  assign req.extent_start   = extent_start;
  assign req.extent_length  = extent_length;
  assign req.request_length = request_length;

  ffef_engine #(
    .MAX_EXTENTS (MAX_EXTENTS),
    .ALIGN_SHIFT (ALIGN_SHIFT)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (in_valid),
    .req_ready     (in_ready),
    .req           (req),
    .region_base   (region_base),
    .region_length (region_length),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  // output register: load when empty or draining, hold while stalled
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status        <= res.status;
      found_address <= res.found_address;
    end
  end

  `ASSERT_ALWAYS(a_reset_out, rst |=> !out_valid, "output valid after reset")

endmodule

FILE: tb/sv/tb.sv
module tb;
  import ffef_pkg::*;

  // Table depth and alignment of the block as built with its defaults.
  localparam int MAX_EXT = MAX_EXTENTS_DEF;
  localparam int ALIGN = ALIGN_SHIFT_DEF;
  localparam longint ALIGN_MASK = (longint'(1) << ALIGN) - 1;

  // The fourth command code has no name in the package; the block ignores it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int PHASE_ITEMS = 200;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_REGION_BASE;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = CMD_CLEAR;
  logic [31:0] extent_start = '0;
  logic [31:0] extent_length = '0;
  logic [31:0] request_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] found_address;

  first_fit_extent_finder DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .extent_start(extent_start),
    .extent_length(extent_length),
    .request_length(request_length),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .found_address(found_address)
  );

  always #2 clk = ~clk;

  // Commands waiting to be offered, and results owed by the block, oldest first.
  request_t pending_cmds[$];
  result_t  owed_results[$];

  int queued_cmds = 0;
  int taken_cmds = 0;
  int mismatches = 0;
  int cycles = 0;

  // Shadow copy of the extent table and of the region registers.
  logic [31:0] shadow_base [MAX_EXT];
  logic [31:0] shadow_len [MAX_EXT];
  int          shadow_count = 0;
  logic [31:0] region_base_q = '0;
  logic [31:0] region_len_q = '0;

  // ---------------------------------------------------------------------------
  // Allocator prediction: apply one command to the shadow table and return
  // the result the block owes for it.
  // ---------------------------------------------------------------------------
  function automatic result_t predict_result(request_t rq);
    result_t r;
    int      pos;
    longint  need;
    longint  cursor;
    longint  region_end;
    bit      hit;
    r.status = STAT_DONE;
    r.found_address = '0;
    case (rq.cmd)
      CMD_CLEAR: shadow_count = 0;
      CMD_ADD: begin
        if (shadow_count >= MAX_EXT) begin
          // Full table: drop the extent, flag it.
          r.status = STAT_FULL;
        end else begin
          // Equal bases go after the ones already stored.
          pos = 0;
          while (pos < shadow_count && !(rq.extent_start < shadow_base[pos])) pos++;
          for (int j = shadow_count; j > pos; j--) begin
            shadow_base[j] = shadow_base[j-1];
            shadow_len[j] = shadow_len[j-1];
          end
          shadow_base[pos] = rq.extent_start;
          shadow_len[pos] = rq.extent_length;
          shadow_count++;
        end
      end
      CMD_QUERY: begin
        if (rq.request_length == 0) begin
          r.status = STAT_NOSPACE;
        end else begin
          // Round up without wrapping; cursor and region end carry bit 32,
          // and every gap is a signed 64-bit difference.
          need = ((longint'({32'd0, rq.request_length}) + ALIGN_MASK) >> ALIGN) << ALIGN;
          cursor = longint'({32'd0, region_base_q});
          hit = 1'b0;
          for (int i = 0; i < shadow_count; i++) begin
            if (!hit) begin
              if (longint'({32'd0, shadow_base[i]}) - cursor >= need) hit = 1'b1;
              else cursor = longint'({32'd0, shadow_base[i]}) +
                            longint'({32'd0, shadow_len[i]});
            end
          end
          region_end = longint'({32'd0, region_base_q}) + longint'({32'd0, region_len_q});
          if (!hit && region_end - cursor >= need) hit = 1'b1;
          if (hit) begin
            r.status = STAT_FOUND;
            r.found_address = cursor[31:0];
          end else begin
            r.status = STAT_NOSPACE;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(logic [1:0] c, logic [31:0] s, logic [31:0] l, logic [31:0] q);
    request_t rq;
    rq.cmd = c;
    rq.extent_start = s;
    rq.extent_length = l;
    rq.request_length = q;
    pending_cmds.push_back(rq);
    queued_cmds++;
  endtask

  // Span used to place random extents; a zero-length region still gets a window.
  function automatic logic [31:0] region_span();
    return (region_len_q == 0) ? 32'h400 : region_len_q;
  endfunction

  function automatic logic [31:0] pick_base(logic [31:0] span);
    logic [31:0] off;
    if ($urandom_range(0, 7) == 0) return $urandom;
    off = $urandom_range(0, span - 1);
    if ($urandom_range(0, 1) == 0) off = off & ~32'h7;
    return region_base_q + off;
  endfunction

  function automatic logic [31:0] pick_extent_len(logic [31:0] span);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom;
      default: return $urandom_range(1, span / 8 + 1);
    endcase
  endfunction

  function automatic logic [31:0] pick_request(logic [31:0] span);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
      2, 3:    return $urandom_range(1, 64);
      4, 5, 6: return $urandom_range(1, span / 4 + 1);
      7, 8:    return $urandom_range(1, span);
      default: return $urandom;
    endcase
  endfunction

  // One round: mostly clear, fill with extents, then ask for space.
  // Some rounds skip the clear so the table runs full; a few are pure noise.
  task automatic queue_round();
    logic [31:0] span;
    logic [31:0] last_base;
    int          n_add;
    span = region_span();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6))
        queue_cmd(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
      return;
    end
    if ($urandom_range(0, 4) != 0) queue_cmd(CMD_CLEAR, $urandom, $urandom, $urandom);
    n_add = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 8);
    last_base = pick_base(span);
    repeat (n_add) begin
      // Reuse the previous base now and then to pile up equal keys.
      if ($urandom_range(0, 7) != 0) last_base = pick_base(span);
      queue_cmd(CMD_ADD, last_base, pick_extent_len(span), $urandom);
    end
    repeat ($urandom_range(1, 6)) queue_cmd(CMD_QUERY, $urandom, $urandom, pick_request(span));
    if ($urandom_range(0, 2) == 0) begin
      queue_cmd(CMD_ADD, pick_base(span), pick_extent_len(span), $urandom);
      queue_cmd(CMD_QUERY, $urandom, $urandom, pick_request(span));
    end
  endtask

  // Write both region registers back to back and mirror them in the shadow.
  task automatic program_region(logic [31:0] base, logic [31:0] len);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_REGION_BASE;
    cfg_data <= base;
    @(posedge clk);
    cfg_index <= REG_REGION_LENGTH;
    cfg_data <= len;
    @(posedge clk);
    cfg_write <= 1'b0;
    region_base_q = base;
    region_len_q = len;
    @(negedge clk);
  endtask

  // Settle on the falling edge, when every update of the rising edge is done.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || owed_results.size() != 0);
    // Every command owes a result, so the block is idle now; leave some slack.
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_phase(logic [31:0] base, logic [31:0] len);
    int start;
    program_region(base, len);
    start = queued_cmds;
    while (queued_cmds - start < PHASE_ITEMS) queue_round();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: a 4 KiB region at 0x1000.
    program_region(32'h0000_1000, 32'h0000_1000);
    queue_cmd(CMD_QUERY, '0, '0, 32'd1);            // empty table, round 1 up to 8
    queue_cmd(CMD_QUERY, '0, '0, 32'd0);            // zero request
    queue_cmd(CMD_QUERY, '0, '0, 32'hFFFF_FFFF);    // rounding must not wrap
    queue_cmd(CMD_UNUSED, '1, '1, '1);              // ignored command
    queue_cmd(CMD_ADD, 32'h0000_1100, 32'h10, '0);
    queue_cmd(CMD_ADD, 32'h0000_1100, 32'h20, '0);  // equal base sorts after
    queue_cmd(CMD_ADD, 32'h0, 32'h0, '0);           // below the region, zero length
    queue_cmd(CMD_QUERY, '0, '0, 32'h100);          // first gap opens below region
    queue_cmd(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);  // cursor past 2^32
    queue_cmd(CMD_QUERY, '0, '0, 32'd8);
    for (int i = 0; i < 12; i++)
      queue_cmd(CMD_ADD, 32'h0000_1200 + i * 32'h40, 32'h20, '0);
    queue_cmd(CMD_ADD, 32'h0000_1180, 32'h8, '0);   // table full, dropped
    queue_cmd(CMD_QUERY, '0, '0, 32'd5);
    queue_cmd(CMD_CLEAR, '1, '1, '1);
    queue_cmd(CMD_QUERY, '0, '0, 32'h1000);         // exactly the whole region
    wait_drained();

    random_phase(32'h0000_1000, 32'h0000_1000);
    random_phase(32'h0, 32'h0);
    random_phase(32'h0, 32'hFFFF_FFFF);

    // Region at the top of the address space: it runs past 2^32, and the gap after the extent starts above 2^32.
    program_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(CMD_CLEAR, '0, '0, '0);
    queue_cmd(CMD_ADD, 32'hFFFF_FFF0, 32'h20, '0);
    queue_cmd(CMD_QUERY, '0, '0, 32'd8);            // found address wraps mod 2^32
    queue_cmd(CMD_QUERY, '0, '0, 32'hFFFF_FFF9);    // needs 2^32, tail too short
    wait_drained();
    random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF);

    random_phase($urandom, $urandom_range(32'h100, 32'h10_0000));
    random_phase(32'h8000_0000, 32'h0001_0000);

    // Let any stray result show up before judging the run.
    repeat (64) @(posedge clk);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Command driver: offer queued commands in bursts of random length with
  // random gaps. Hold valid and payload until the transfer happens.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    request_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        nxt = pending_cmds.pop_front();
        cmd <= nxt.cmd;
        extent_start <= nxt.extent_start;
        extent_length <= nxt.extent_length;
        request_length <= nxt.request_length;
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // A quarter of the bursts run straight into the next one.
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: stall on a pattern of its own. The mode changes every so
  // often; one long hold comes early so the block backs up and drops in_ready
  // while the driver keeps offering, and rare long holds follow at random.
  // ---------------------------------------------------------------------------
  int  hold_left = 0;
  int  mode_left = 0;
  int  rx_mode = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && taken_cmds >= 60) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 1999) == 0) begin
      hold_left = $urandom_range(50, 300);
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 0);
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result transfer against the oldest owed result, then
  // predict the result of a command transfer on the same edge. A result can
  // never stem from a command taken on the same edge, so the order is safe.
  // ---------------------------------------------------------------------------
  task automatic flag_result(string why, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected status %0d addr %08h, got status %0d addr %08h",
               why, want.status, want.found_address, got.status, got.found_address);
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.status = status;
        got.found_address = found_address;
        if (owed_results.size() == 0) begin
          flag_result("result with nothing owed", '0, got);
        end else begin
          want = owed_results.pop_front();
          if (got.status !== want.status || got.found_address !== want.found_address)
            flag_result("result mismatch", want, got);
        end
      end
      if (in_valid && in_ready) begin
        owed_results.push_back(predict_result({cmd, extent_start, extent_length,
                                               request_length}));
        taken_cmds++;
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
